>>> design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, codes, tables and helpers for the quaternion to Euler block.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STEPS    = 16;
    localparam int TAB_LEN         = 24;
    localparam int NSTEPS          = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int STEP_W          = 5;

    localparam int ANGLE_W = 17;
    localparam int QW      = 32;
    localparam int PW      = 2 * QW + 1;
    localparam int QPW     = PW - 30;
    localparam int MCNT_W  = $clog2(QW);

    localparam int SQ_W     = 62;
    localparam int ROOT_W   = 31;
    localparam int REM_W    = 34;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQCNT_W  = $clog2(SQ_STEPS);

    localparam int CW     = 40;
    localparam int AW     = 36;
    localparam int MW     = AW - 21 + ANGLE_FRAC_BITS;
    localparam int DW     = MW + 1;
    localparam int DCNT_W = $clog2(MW);
    localparam int VW     = DW + 1;

    localparam logic signed [AW-1:0] PI_Q32 = AW'(64'sd13493037705);
    localparam logic signed [VW-1:0] FULL_V = VW'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [VW-1:0] HALF_V = VW'(180 << ANGLE_FRAC_BITS);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_PITCH_RATE = 2'd0;
    localparam logic [1:0] REG_ROLL_RATE  = 2'd1;
    localparam logic [1:0] REG_YAW_RATE   = 2'd2;

    localparam int NPROD = 10;
    localparam int PIDX_W = 4;
    localparam int P_WY = 0;
    localparam int P_XZ = 1;
    localparam int P_YZ = 2;
    localparam int P_WX = 3;
    localparam int P_XX = 4;
    localparam int P_YY = 5;
    localparam int P_XY = 6;
    localparam int P_WZ = 7;
    localparam int P_WW = 8;
    localparam int P_ZZ = 9;

    localparam logic [1:0] J_PITCH = 2'd0;
    localparam logic [1:0] J_ROLL  = 2'd1;
    localparam logic [1:0] J_YAW   = 2'd2;

    typedef enum logic [1:0] {
        COMP_W,
        COMP_X,
        COMP_Y,
        COMP_Z
    } comp_t;

    typedef struct packed {
        comp_t a;
        comp_t b;
    } prod_sel_t;

    typedef struct packed {
        logic signed [CW-1:0] n;
        logic signed [CW-1:0] d;
    } cord_op_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_MUL,
        TS_SQMUL,
        TS_SQRT,
        TS_CORD,
        TS_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_SCALE,
        CS_DIV
    } cord_state_t;

    function automatic prod_sel_t prod_sel(input logic [PIDX_W-1:0] idx);
        prod_sel_t r;
        case (idx)
            PIDX_W'(P_WY): r = '{COMP_W, COMP_Y};
            PIDX_W'(P_XZ): r = '{COMP_X, COMP_Z};
            PIDX_W'(P_YZ): r = '{COMP_Y, COMP_Z};
            PIDX_W'(P_WX): r = '{COMP_W, COMP_X};
            PIDX_W'(P_XX): r = '{COMP_X, COMP_X};
            PIDX_W'(P_YY): r = '{COMP_Y, COMP_Y};
            PIDX_W'(P_XY): r = '{COMP_X, COMP_Y};
            PIDX_W'(P_WZ): r = '{COMP_W, COMP_Z};
            PIDX_W'(P_WW): r = '{COMP_W, COMP_W};
            PIDX_W'(P_ZZ): r = '{COMP_Z, COMP_Z};
            default:       r = '{COMP_W, COMP_W};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] atan_tab(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd3373259426;
            5'd1:    r = 32'd1991351317;
            5'd2:    r = 32'd1052175346;
            5'd3:    r = 32'd534100635;
            5'd4:    r = 32'd268086748;
            5'd5:    r = 32'd134174063;
            5'd6:    r = 32'd67103403;
            5'd7:    r = 32'd33553749;
            5'd8:    r = 32'd16777131;
            5'd9:    r = 32'd8388597;
            5'd10:   r = 32'd4194303;
            5'd11:   r = 32'd2097152;
            5'd12:   r = 32'd1048576;
            5'd13:   r = 32'd524288;
            5'd14:   r = 32'd262144;
            5'd15:   r = 32'd131072;
            5'd16:   r = 32'd65536;
            5'd17:   r = 32'd32768;
            5'd18:   r = 32'd16384;
            5'd19:   r = 32'd8192;
            5'd20:   r = 32'd4096;
            5'd21:   r = 32'd2048;
            5'd22:   r = 32'd1024;
            5'd23:   r = 32'd512;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] wrap_angle(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] r;
        r = v;
        if (r < 0) r = r + FULL_V;
        if (r < 0) r = r + FULL_V;
        if (r >= FULL_V) r = r - FULL_V;
        if (r >= FULL_V) r = r - FULL_V;
        if (r > HALF_V) r = r - FULL_V;
        return r[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/quaternion_to_euler_with_offsets.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_with_offsets
// Q30 quaternion to pitch, roll and yaw in 1/256 degree, with drifting
// per-axis offsets.
// ----------------------------------------------------------------------------
// A sample transfer (tuser 0) passes through the states MUL, SQMUL, SQRT,
// CORD and OUT. Eleven products run on a bit-serial multiplier, ten in MUL
// and the square of s in SQMUL, and the square root follows. Three CORDIC
// passes come next, each with 16 rotations, a scaling step and a 23-step
// divide by ten. OUT loads the output register. A tick transfer (tuser 1)
// is absorbed in the idle state and gives no result. One sample is in work
// at a time, so no new sample is accepted until the last one has left OUT.
// A finished result sits in the output register while the next sample is
// accepted. Angles are wrapped into (-180, 180] degrees.
`default_nettype none

module quaternion_to_euler_with_offsets (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // quat_w, quat_x, quat_y, quat_z
    input  wire logic [127:0]                 s_tdata,
    // action
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pitch_angle, roll_angle, yaw_angle, zero fill
    output logic [55:0]                       m_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [qte_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    qte_pkg::top_state_t               state_reg;
    qte_pkg::top_state_t               state_next;

    logic signed [qte_pkg::ANGLE_W-1:0] pitch_rate_reg, roll_rate_reg, yaw_rate_reg;
    logic signed [qte_pkg::ANGLE_W-1:0] pitch_off_reg, roll_off_reg, yaw_off_reg;
    logic signed [qte_pkg::ANGLE_W-1:0] pitch_ang_reg, roll_ang_reg, yaw_ang_reg;
    logic signed [qte_pkg::QW-1:0]     w_reg, x_reg, y_reg, z_reg;
    logic signed [qte_pkg::QPW-1:0]    p_reg [qte_pkg::NPROD];
    logic [qte_pkg::PIDX_W-1:0]        idx_reg;
    logic signed [qte_pkg::QW-1:0]     s_reg;
    logic [qte_pkg::ROOT_W-1:0]        c_reg;
    logic [1:0]                        job_reg;
    logic                              mul_go_reg, sqrt_go_reg, cord_go_reg;
    logic                              m_tvalid_reg;
    logic [55:0]                       m_tdata_reg;

    logic                              accept, wr, out_free;
    qte_pkg::prod_sel_t                sel;
    logic signed [qte_pkg::QW-1:0]     op_a, op_b;
    logic                              mul_done;
    logic signed [qte_pkg::PW-1:0]     mul_prod;
    logic                              sqrt_done;
    logic [qte_pkg::ROOT_W-1:0]        sqrt_root;
    logic [qte_pkg::SQ_W-1:0]          sq_in;
    qte_pkg::cord_op_t                 cop;
    logic                              cord_done;
    logic signed [qte_pkg::DW-1:0]     cord_deg;
    logic signed [qte_pkg::CW-1:0]     s_full;
    logic signed [qte_pkg::QW-1:0]     s_clamp;
    logic signed [qte_pkg::ANGLE_W-1:0] off_sel;
    logic signed [qte_pkg::ANGLE_W-1:0] ang_new;

    function automatic logic signed [qte_pkg::QW-1:0] comp_val(
        input qte_pkg::comp_t c,
        input logic signed [qte_pkg::QW-1:0] w,
        input logic signed [qte_pkg::QW-1:0] x,
        input logic signed [qte_pkg::QW-1:0] y,
        input logic signed [qte_pkg::QW-1:0] z
    );
        logic signed [qte_pkg::QW-1:0] r;
        case (c)
            qte_pkg::COMP_W: r = w;
            qte_pkg::COMP_X: r = x;
            qte_pkg::COMP_Y: r = y;
            qte_pkg::COMP_Z: r = z;
            default:         r = w;
        endcase
        return r;
    endfunction

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;
    assign s_tready = (state_reg == qte_pkg::TS_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        case (paddr[3:2])
            qte_pkg::REG_PITCH_RATE: prdata = 32'($unsigned(pitch_rate_reg));
            qte_pkg::REG_ROLL_RATE:  prdata = 32'($unsigned(roll_rate_reg));
            qte_pkg::REG_YAW_RATE:   prdata = 32'($unsigned(yaw_rate_reg));
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_rate_reg <= '0;
            roll_rate_reg  <= '0;
            yaw_rate_reg   <= '0;
        end else if (wr) begin
            case (paddr[3:2])
                qte_pkg::REG_PITCH_RATE: pitch_rate_reg <= pwdata[qte_pkg::ANGLE_W-1:0];
                qte_pkg::REG_ROLL_RATE:  roll_rate_reg  <= pwdata[qte_pkg::ANGLE_W-1:0];
                qte_pkg::REG_YAW_RATE:   yaw_rate_reg   <= pwdata[qte_pkg::ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sel  = qte_pkg::prod_sel(idx_reg);
        op_a = (state_reg == qte_pkg::TS_SQMUL) ? s_reg
             : comp_val(sel.a, w_reg, x_reg, y_reg, z_reg);
        op_b = (state_reg == qte_pkg::TS_SQMUL) ? s_reg
             : comp_val(sel.b, w_reg, x_reg, y_reg, z_reg);
        sq_in = (qte_pkg::SQ_W'(1) << 60) - {1'b0, mul_prod[60:0]};

        s_full = (qte_pkg::CW'(p_reg[qte_pkg::P_WY]) - qte_pkg::CW'(p_reg[qte_pkg::P_XZ])) <<< 1;
        if (s_full > qte_pkg::CW'(64'sd1073741824))
            s_clamp = qte_pkg::QW'(64'sd1073741824);
        else if (s_full < -qte_pkg::CW'(64'sd1073741824))
            s_clamp = -qte_pkg::QW'(64'sd1073741824);
        else
            s_clamp = s_full[qte_pkg::QW-1:0];

        case (job_reg)
            qte_pkg::J_PITCH: begin
                cop.n = qte_pkg::CW'(s_reg);
                cop.d = qte_pkg::CW'({1'b0, c_reg});
                off_sel = pitch_off_reg;
            end
            qte_pkg::J_ROLL: begin
                cop.n = (qte_pkg::CW'(p_reg[qte_pkg::P_YZ]) + qte_pkg::CW'(p_reg[qte_pkg::P_WX])) <<< 1;
                cop.d = qte_pkg::CW'(64'sd1073741824)
                      - ((qte_pkg::CW'(p_reg[qte_pkg::P_XX]) + qte_pkg::CW'(p_reg[qte_pkg::P_YY])) <<< 1);
                off_sel = roll_off_reg;
            end
            default: begin
                cop.n = (qte_pkg::CW'(p_reg[qte_pkg::P_XY]) + qte_pkg::CW'(p_reg[qte_pkg::P_WZ])) <<< 1;
                cop.d = qte_pkg::CW'(p_reg[qte_pkg::P_WW]) + qte_pkg::CW'(p_reg[qte_pkg::P_XX])
                      - qte_pkg::CW'(p_reg[qte_pkg::P_YY]) - qte_pkg::CW'(p_reg[qte_pkg::P_ZZ]);
                off_sel = yaw_off_reg;
            end
        endcase
        ang_new = qte_pkg::wrap_angle(qte_pkg::VW'(cord_deg) + qte_pkg::VW'(off_sel));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qte_pkg::TS_IDLE: begin
                if (accept && !s_tuser) state_next = qte_pkg::TS_MUL;
            end
            qte_pkg::TS_MUL: begin
                if (mul_done && idx_reg == qte_pkg::PIDX_W'(qte_pkg::NPROD - 1))
                    state_next = qte_pkg::TS_SQMUL;
            end
            qte_pkg::TS_SQMUL: begin
                if (mul_done) state_next = qte_pkg::TS_SQRT;
            end
            qte_pkg::TS_SQRT: begin
                if (sqrt_done) state_next = qte_pkg::TS_CORD;
            end
            qte_pkg::TS_CORD: begin
                if (cord_done && job_reg == qte_pkg::J_YAW) state_next = qte_pkg::TS_OUT;
            end
            qte_pkg::TS_OUT: begin
                if (out_free) state_next = qte_pkg::TS_IDLE;
            end
            default: state_next = qte_pkg::TS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qte_pkg::TS_IDLE;
            mul_go_reg    <= 1'b0;
            sqrt_go_reg   <= 1'b0;
            cord_go_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            pitch_off_reg <= '0;
            roll_off_reg  <= '0;
            yaw_off_reg   <= '0;
            idx_reg       <= '0;
            job_reg       <= qte_pkg::J_PITCH;
        end else begin
            state_reg   <= state_next;
            mul_go_reg  <= 1'b0;
            sqrt_go_reg <= 1'b0;
            cord_go_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                qte_pkg::TS_IDLE: begin
                    if (accept && s_tuser) begin
                        pitch_off_reg <= qte_pkg::wrap_angle(
                            qte_pkg::VW'(pitch_off_reg) + qte_pkg::VW'(pitch_rate_reg));
                        roll_off_reg  <= qte_pkg::wrap_angle(
                            qte_pkg::VW'(roll_off_reg) + qte_pkg::VW'(roll_rate_reg));
                        yaw_off_reg   <= qte_pkg::wrap_angle(
                            qte_pkg::VW'(yaw_off_reg) + qte_pkg::VW'(yaw_rate_reg));
                    end else if (accept) begin
                        idx_reg    <= '0;
                        mul_go_reg <= 1'b1;
                    end
                end
                qte_pkg::TS_MUL: begin
                    if (mul_done) begin
                        idx_reg    <= idx_reg + 1'b1;
                        mul_go_reg <= 1'b1;
                    end
                end
                qte_pkg::TS_SQMUL: begin
                    if (mul_done) sqrt_go_reg <= 1'b1;
                end
                qte_pkg::TS_SQRT: begin
                    if (sqrt_done) begin
                        job_reg     <= qte_pkg::J_PITCH;
                        cord_go_reg <= 1'b1;
                    end
                end
                qte_pkg::TS_CORD: begin
                    if (cord_done && job_reg != qte_pkg::J_YAW) begin
                        job_reg     <= job_reg + 1'b1;
                        cord_go_reg <= 1'b1;
                    end
                end
                qte_pkg::TS_OUT: begin
                    if (out_free) m_tvalid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_tuser) begin
            w_reg <= s_tdata[31:0];
            x_reg <= s_tdata[63:32];
            y_reg <= s_tdata[95:64];
            z_reg <= s_tdata[127:96];
        end
        if (state_reg == qte_pkg::TS_MUL && mul_done) begin
            p_reg[idx_reg] <= mul_prod[qte_pkg::PW-1:30];
            if (idx_reg == qte_pkg::PIDX_W'(qte_pkg::NPROD - 1)) s_reg <= s_clamp;
        end
        if (state_reg == qte_pkg::TS_SQRT && sqrt_done) c_reg <= sqrt_root;
        if (state_reg == qte_pkg::TS_CORD && cord_done) begin
            case (job_reg)
                qte_pkg::J_PITCH: pitch_ang_reg <= ang_new;
                qte_pkg::J_ROLL:  roll_ang_reg  <= ang_new;
                default:          yaw_ang_reg   <= ang_new;
            endcase
        end
        if (state_reg == qte_pkg::TS_OUT && out_free)
            m_tdata_reg <= {5'b0, yaw_ang_reg, roll_ang_reg, pitch_ang_reg};
    end

    qte_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    qte_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_go_reg),
        .v       (sq_in),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    qte_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_go_reg),
        .op      (cop),
        .done    (cord_done),
        .deg     (cord_deg)
    );

endmodule

`default_nettype wire

>>> design/qte_mul.sv
// ----------------------------------------------------------------------------
// qte_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_mul (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [qte_pkg::QW-1:0]     a,
    input  wire logic signed [qte_pkg::QW-1:0]     b,
    output logic                                   done,
    output logic signed [qte_pkg::PW-1:0]          prod
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [qte_pkg::MCNT_W-1:0]        cnt_reg;
    logic signed [qte_pkg::QW-1:0]     a_reg;
    logic [qte_pkg::QW-1:0]            b_reg;
    logic signed [qte_pkg::QW:0]       hi_reg;
    logic [qte_pkg::QW-1:0]            lo_reg;

    logic signed [qte_pkg::QW+1:0]     addend;
    logic signed [qte_pkg::QW+1:0]     sum_next;
    logic                              last;

    always_comb begin
        last     = (cnt_reg == qte_pkg::MCNT_W'(qte_pkg::QW - 1));
        addend   = b_reg[0] ? (qte_pkg::QW+2)'(a_reg) : '0;
        sum_next = last ? ((qte_pkg::QW+2)'(hi_reg) - addend)
                        : ((qte_pkg::QW+2)'(hi_reg) + addend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (busy_reg) begin
            hi_reg <= sum_next[qte_pkg::QW+1:1];
            lo_reg <= {sum_next[0], lo_reg[qte_pkg::QW-1:1]};
            b_reg  <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

>>> design/qte_sqrt.sv
// ----------------------------------------------------------------------------
// qte_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [qte_pkg::SQ_W-1:0]          v,
    output logic                                   done,
    output logic [qte_pkg::ROOT_W-1:0]             root
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [qte_pkg::SQCNT_W-1:0]       cnt_reg;
    logic [qte_pkg::SQ_W-1:0]          v_reg;
    logic [qte_pkg::ROOT_W-1:0]        root_reg;
    logic [qte_pkg::REM_W-1:0]         rem_reg;

    logic [qte_pkg::REM_W-1:0]         rem_sh;
    logic [qte_pkg::REM_W-1:0]         trial;
    logic                              ge;

    always_comb begin
        rem_sh = {rem_reg[qte_pkg::REM_W-3:0], v_reg[qte_pkg::SQ_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == qte_pkg::SQCNT_W'(qte_pkg::SQ_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= v;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            v_reg <= v_reg << 2;
            if (ge) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[qte_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[qte_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> design/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC for atan2, one rotation per cycle, then scaling to
// degrees with a bit-serial divide by ten.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire qte_pkg::cord_op_t                 op,
    output logic                                   done,
    output logic signed [qte_pkg::DW-1:0]          deg
);

    qte_pkg::cord_state_t              state_reg;
    qte_pkg::cord_state_t              state_next;
    logic                              done_reg;
    logic signed [qte_pkg::CW-1:0]     n_reg;
    logic signed [qte_pkg::CW-1:0]     d_reg;
    logic signed [qte_pkg::AW-1:0]     acc_reg;
    logic [qte_pkg::STEP_W-1:0]        i_reg;
    logic [qte_pkg::DCNT_W-1:0]        cnt_reg;
    logic [qte_pkg::MW-1:0]            m_reg;
    logic [qte_pkg::MW-1:0]            quo_reg;
    logic [3:0]                        rem_reg;
    logic                              neg_reg;

    logic signed [qte_pkg::CW-1:0]     n_sh;
    logic signed [qte_pkg::CW-1:0]     d_sh;
    logic signed [qte_pkg::AW-1:0]     tab;
    logic [qte_pkg::AW-1:0]            mag;
    logic [qte_pkg::AW+9:0]            mag573;
    logic [qte_pkg::MW-1:0]            m_next;
    logic [4:0]                        t;
    logic                              ge;
    logic                              zero_in;
    logic                              last_iter;
    logic                              last_div;

    always_comb begin
        n_sh      = n_reg >>> i_reg;
        d_sh      = d_reg >>> i_reg;
        tab       = qte_pkg::AW'(qte_pkg::atan_tab(i_reg));
        mag       = acc_reg[qte_pkg::AW-1] ? qte_pkg::AW'(-acc_reg) : qte_pkg::AW'(acc_reg);
        mag573    = ((qte_pkg::AW+10)'(mag) << 9) + ((qte_pkg::AW+10)'(mag) << 6)
                  - ((qte_pkg::AW+10)'(mag) << 1) - (qte_pkg::AW+10)'(mag);
        m_next    = qte_pkg::MW'(mag573[qte_pkg::AW+9:32-qte_pkg::ANGLE_FRAC_BITS])
                  + qte_pkg::MW'(5);
        t         = {rem_reg, m_reg[qte_pkg::MW-1]};
        ge        = (t >= 5'd10);
        zero_in   = (op.n == '0) && (op.d == '0);
        last_iter = (i_reg == qte_pkg::STEP_W'(qte_pkg::NSTEPS - 1));
        last_div  = (cnt_reg == qte_pkg::DCNT_W'(qte_pkg::MW - 1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qte_pkg::CS_IDLE: begin
                if (start) state_next = zero_in ? qte_pkg::CS_SCALE : qte_pkg::CS_ITER;
            end
            qte_pkg::CS_ITER: begin
                if (last_iter) state_next = qte_pkg::CS_SCALE;
            end
            qte_pkg::CS_SCALE: state_next = qte_pkg::CS_DIV;
            qte_pkg::CS_DIV: begin
                if (last_div) state_next = qte_pkg::CS_IDLE;
            end
            default: state_next = qte_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qte_pkg::CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == qte_pkg::CS_DIV) && last_div;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            qte_pkg::CS_IDLE: begin
                i_reg <= '0;
                if (zero_in) begin
                    acc_reg <= '0;
                    n_reg   <= op.n;
                    d_reg   <= op.d;
                end else if (op.d < 0) begin
                    acc_reg <= (op.n >= 0) ? qte_pkg::PI_Q32 : -qte_pkg::PI_Q32;
                    n_reg   <= -op.n;
                    d_reg   <= -op.d;
                end else begin
                    acc_reg <= '0;
                    n_reg   <= op.n;
                    d_reg   <= op.d;
                end
            end
            qte_pkg::CS_ITER: begin
                i_reg <= i_reg + 1'b1;
                if (n_reg >= 0) begin
                    d_reg   <= d_reg + n_sh;
                    n_reg   <= n_reg - d_sh;
                    acc_reg <= acc_reg + tab;
                end else begin
                    d_reg   <= d_reg - n_sh;
                    n_reg   <= n_reg + d_sh;
                    acc_reg <= acc_reg - tab;
                end
            end
            qte_pkg::CS_SCALE: begin
                m_reg   <= m_next;
                neg_reg <= acc_reg[qte_pkg::AW-1];
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            qte_pkg::CS_DIV: begin
                m_reg   <= m_reg << 1;
                quo_reg <= {quo_reg[qte_pkg::MW-2:0], ge};
                rem_reg <= ge ? 4'(t - 5'd10) : t[3:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
                i_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign deg  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

`default_nettype wire

>>> verif/quaternion_to_euler_with_offsets_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_with_offsets_tb
// Streams quaternion samples and drift ticks into the block, predicts the
// pitch, roll and yaw angles with an independent fixed-point model, and
// compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_with_offsets_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;
    localparam int   LATENCY    = 700;
    localparam int   IDLE_LIMIT = 200000;
    localparam longint PI_FIX   = 64'sd13493037705;

    typedef struct packed {
        logic        action;
        logic [31:0] qw;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
    } quat_item_t;

    typedef struct packed {
        logic [16:0] pitch;
        logic [16:0] roll;
        logic [16:0] yaw;
    } euler_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [qte_pkg::ADDR_W-1:0] paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    quaternion_to_euler_with_offsets dut (.*);

    quat_item_t pending_items[$];
    euler_t     expected_angles[$];
    longint     rate_pitch, rate_roll, rate_yaw;
    longint     ofs_pitch, ofs_roll, ofs_yaw;
    int         error_count;
    int         idle_cycles;
    bit         hold_off;
    int         hold_cycles;
    int         stall_mode;
    int         gap_left;
    int         burst_left;
    bit         wait_drain;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return shr_floor(a * b, 30);
    endfunction

    function automatic longint isqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint wrap360(longint v);
        longint full;
        longint half;
        longint r;
        full = 360 << qte_pkg::ANGLE_FRAC_BITS;
        half = 180 << qte_pkg::ANGLE_FRAC_BITS;
        r = v % full;
        if (r < 0) r = r + full;
        if (r > half) r = r - full;
        return r;
    endfunction

    function automatic longint cordic_degrees(longint n, longint d);
        longint acc;
        longint nn;
        longint dn;
        longint mag;
        longint q;
        longint tab[24];
        tab = '{64'sd3373259426, 1991351317, 1052175346, 534100635, 268086748, 134174063,
                67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576,
                524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
                1024, 512};
        acc = 0;
        if (n == 0 && d == 0) return 0;
        if (d < 0) begin
            acc = (n >= 0) ? PI_FIX : -PI_FIX;
            n = -n;
            d = -d;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
            if (n >= 0) begin
                dn = d + shr_floor(n, i);
                nn = n - shr_floor(d, i);
                acc = acc + tab[i];
            end else begin
                dn = d - shr_floor(n, i);
                nn = n + shr_floor(d, i);
                acc = acc - tab[i];
            end
            d = dn;
            n = nn;
        end
        mag = (acc < 0) ? -acc : acc;
        q = (((mag * 573) << qte_pkg::ANGLE_FRAC_BITS) + (longint'(5) << 32))
            / (longint'(10) << 32);
        return (acc < 0) ? -q : q;
    endfunction

    function automatic euler_t predict_angles(quat_item_t it);
        longint w, x, y, z, s, c, p, r, yw;
        euler_t e;
        w = longint'($signed(it.qw));
        x = longint'($signed(it.qx));
        y = longint'($signed(it.qy));
        z = longint'($signed(it.qz));
        s = 2 * (qmul(w, y) - qmul(x, z));
        if (s > (longint'(1) << 30)) s = longint'(1) << 30;
        if (s < -(longint'(1) << 30)) s = -(longint'(1) << 30);
        c = isqrt((longint'(1) << 60) - s * s);
        p = cordic_degrees(s, c);
        r = cordic_degrees(2 * (qmul(y, z) + qmul(w, x)),
                           (longint'(1) << 30) - 2 * (qmul(x, x) + qmul(y, y)));
        yw = cordic_degrees(2 * (qmul(x, y) + qmul(w, z)),
                            qmul(w, w) + qmul(x, x) - qmul(y, y) - qmul(z, z));
        e.pitch = 17'(wrap360(p + ofs_pitch));
        e.roll  = 17'(wrap360(r + ofs_roll));
        e.yaw   = 17'(wrap360(yw + ofs_yaw));
        return e;
    endfunction

    function automatic void apply_item(quat_item_t it);
        if (it.action == ACT_TICK) begin
            ofs_pitch = wrap360(ofs_pitch + rate_pitch);
            ofs_roll  = wrap360(ofs_roll + rate_roll);
            ofs_yaw   = wrap360(ofs_yaw + rate_yaw);
        end else begin
            expected_angles.push_back(predict_angles(it));
        end
    endfunction

    task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
                 $signed(want), $realtime);
        error_count++;
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            s_tvalid <= 1'b1;
        end else if (pending_items.size() == 0 || gap_left > 0 ||
                     (wait_drain && expected_angles.size() != 0)) begin
            s_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end else begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_items[0].action;
            s_tdata  <= {pending_items[0].qz, pending_items[0].qy,
                         pending_items[0].qx, pending_items[0].qw};
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            apply_item(pending_items.pop_front());
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
            if (hold_cycles > 0) hold_cycles--;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 499) == 0) stall_mode = $urandom_range(0, 2);
        end
    end

    // monitor
    always @(posedge aclk) begin
        euler_t got;
        euler_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pitch = m_tdata[16:0];
            got.roll  = m_tdata[33:17];
            got.yaw   = m_tdata[50:34];
            if (expected_angles.size() == 0) begin
                $display("unexpected output transfer at %0t", $realtime);
                error_count++;
            end else begin
                want = expected_angles.pop_front();
                if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_rate(logic [1:0] idx, longint value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= qte_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            qte_pkg::REG_PITCH_RATE: rate_pitch = longint'($signed(17'(value)));
            qte_pkg::REG_ROLL_RATE:  rate_roll  = longint'($signed(17'(value)));
            qte_pkg::REG_YAW_RATE:   rate_yaw   = longint'($signed(17'(value)));
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_block();
        while (pending_items.size() != 0 || s_tvalid || expected_angles.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [31:0] unit_comp();
        return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    function automatic quat_item_t sample_item(logic [31:0] w, logic [31:0] x,
                                               logic [31:0] y, logic [31:0] z);
        quat_item_t it;
        it.action = ACT_SAMPLE;
        it.qw = w;
        it.qx = x;
        it.qy = y;
        it.qz = z;
        return it;
    endfunction

    // random item: a drift tick, raw components, or a unit quaternion normalized in real arithmetic
    function automatic quat_item_t random_item();
        quat_item_t it;
        real a, b, c, d, nrm;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            it = sample_item($urandom, $urandom, $urandom, $urandom);
            it.action = ACT_TICK;
            if (kind == 0) it = sample_item($urandom, $urandom, $urandom, $urandom);
        end else if (kind < 6) begin
            it = sample_item(unit_comp(), unit_comp(), unit_comp(), unit_comp());
        end else begin
            a = $itor($signed($urandom)) ;
            b = $itor($signed($urandom));
            c = $itor($signed($urandom));
            d = $itor($signed($urandom));
            nrm = $sqrt(a * a + b * b + c * c + d * d);
            if (nrm == 0.0) nrm = 1.0;
            it = sample_item(32'($rtoi(a / nrm * 1073741823.0)),
                             32'($rtoi(b / nrm * 1073741823.0)),
                             32'($rtoi(c / nrm * 1073741823.0)),
                             32'($rtoi(d / nrm * 1073741823.0)));
        end
        return it;
    endfunction

    function automatic quat_item_t tick_item();
        quat_item_t it;
        it = sample_item($urandom, $urandom, $urandom, $urandom);
        it.action = ACT_TICK;
        return it;
    endfunction

    initial begin
        longint rate_set[5];
        logic [31:0] one;
        logic [31:0] neg;
        rate_set = '{0, 46080, -46080, 1, -25599};
        one = 32'h4000_0000;
        neg = 32'hC000_0000;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        stall_mode = 0;
        gap_left = 0;
        burst_left = 0;
        wait_drain = 1'b0;
        rate_pitch = 0;
        rate_roll = 0;
        rate_yaw = 0;
        ofs_pitch = 0;
        ofs_roll = 0;
        ofs_yaw = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: identity, axes, zero vector, saturated asin, extremes, a tick, two mixed rotations
        pending_items.push_back(sample_item(one, 0, 0, 0));
        pending_items.push_back(sample_item(0, 0, 0, 0));
        pending_items.push_back(sample_item(0, one, 0, 0));
        pending_items.push_back(sample_item(0, 0, one, 0));
        pending_items.push_back(sample_item(0, 0, 0, one));
        pending_items.push_back(sample_item(neg, 0, 0, 0));
        pending_items.push_back(sample_item(one, 0, one, 0));
        pending_items.push_back(sample_item(one, 0, neg, 0));
        pending_items.push_back(sample_item(32'h7FFF_FFFF, 32'h8000_0000,
                                            32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(sample_item(32'h8000_0000, 32'h8000_0000,
                                            32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(sample_item(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                            32'h0000_0001, 32'hFFFF_FFFF));
        pending_items.push_back(tick_item());
        pending_items.push_back(sample_item(32'h2D41_3CCC, 32'h2D41_3CCC, 0, 0));
        pending_items.push_back(sample_item(32'h2000_0000, 32'h2000_0000,
                                            32'h2000_0000, 32'h2000_0000));
        drain_block();

        for (int phase = 0; phase < 8; phase++) begin
            write_rate(qte_pkg::REG_PITCH_RATE, rate_set[phase % 5]);
            write_rate(qte_pkg::REG_ROLL_RATE, rate_set[(phase + 1) % 5]);
            write_rate(qte_pkg::REG_YAW_RATE,
                       (phase == 7) ? longint'($signed($urandom_range(0, 92160))) - 46080
                                    : rate_set[(phase + 2) % 5]);
            // several ticks drive the offsets across the wrap point
            for (int k = 0; k < 6; k++) pending_items.push_back(tick_item());
            for (int k = 0; k < 200; k++) pending_items.push_back(random_item());
            if (phase == 2) begin
                hold_cycles = 6000;
                hold_off = 1'b1;
                while (hold_cycles > 0) @(posedge aclk);
                hold_off = 1'b0;
            end
            if (phase == 4) begin
                wait_drain = 1'b1;
                repeat (3000) @(posedge aclk);
                wait_drain = 1'b0;
            end
            drain_block();
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/qte_pkg.sv
design/qte_mul.sv
design/qte_sqrt.sv
design/qte_cordic.sv
design/quaternion_to_euler_with_offsets.sv
verif/quaternion_to_euler_with_offsets_tb.sv
